// File: rtl/lurt_pkg.sv
// Shared sizes and helpers for the longest repeat-free run tracker.
// No dependencies; imported by longest_unique_run_tracker.
`default_nettype none
package lurt_pkg;

    localparam int ALPHABET = 256;
    localparam int CODE_W   = $clog2(ALPHABET);
    localparam int MAX_POS  = 65535;
    localparam int POS_W    = $clog2(MAX_POS + 1);
    localparam int LEN_W    = POS_W + 1;
    localparam int OUT_W    = 16;

    typedef logic [CODE_W-1:0] code_t;
    typedef logic [POS_W-1:0]  pos_t;
    typedef logic [LEN_W-1:0]  len_t;
    typedef logic [OUT_W-1:0]  out_len_t;

    localparam pos_t     POS_MAX = pos_t'(MAX_POS);
    localparam out_len_t OUT_MAX = {OUT_W{1'b1}};

    // clamp a run length to the output field width
    function automatic out_len_t sat_len(input len_t v);
        if (LEN_W > OUT_W && v > len_t'(OUT_MAX))
            return OUT_MAX;
        else
            return out_len_t'(v);
    endfunction

endpackage
`default_nettype wire

// File: rtl/longest_unique_run_tracker.sv
// Longest repeat-free run tracker, top level.
// Depends on lurt_pkg (sizes, types, length clamp).
//
// Takes one byte per cycle and returns one result per byte: the longest
// repeat-free run so far, the current window length, the end mark and a
// sticky overflow flag. A new byte is taken every cycle while results flow;
// a byte's result passes through the compute stage into the output register.
// The last position of each byte value lives in a 256 x 16 synchronous RAM:
// it is read when the byte is taken and written when its result is committed,
// with the previous write forwarded when both address the same value.
// Seen flags are flip-flops, so a string end clears all state at once and no
// clearing pass is needed.
`default_nettype none
module longest_unique_run_tracker
    import lurt_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       char_code,
    input  wire logic             end_of_string,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output logic [OUT_W-1:0]      best_length,
    output logic [OUT_W-1:0]      window_length,
    output logic                  string_done,
    output logic                  overflow
);

    // position table
    pos_t            last_pos_mem [ALPHABET];
    logic [ALPHABET-1:0] seen_reg;

    // input side
    pos_t pos_reg;
    logic ovf_reg;

    // compute stage
    logic s1_valid_reg;
    code_t s1_code_reg;
    pos_t s1_idx_reg;
    logic s1_last_reg;
    logic s1_ovf_reg;
    logic s1_seen_reg;
    logic s1_fwd_reg;
    pos_t s1_fwd_idx_reg;
    pos_t rd_data_reg;

    len_t ws_reg;
    len_t best_reg;

    // output register
    logic out_valid_reg;
    out_len_t best_out_reg;
    out_len_t wlen_out_reg;
    logic done_out_reg;
    logic ovf_out_reg;

    logic accept;
    logic commit;
    code_t in_code;
    logic at_max;
    logic ovf_item;

    pos_t last_pos;
    logic seen;
    len_t cand;
    len_t idx_p1;
    len_t ws_next;
    len_t wlen;
    len_t best_next;

    assign in_code  = code_t'(char_code);
    assign commit   = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || commit;
    assign accept   = in_valid && in_ready;
    assign at_max   = (pos_reg == POS_MAX);
    assign ovf_item = ovf_reg || at_max;

    always_comb
    begin
        last_pos  = s1_fwd_reg ? s1_fwd_idx_reg : rd_data_reg;
        seen      = s1_seen_reg || s1_fwd_reg;
        cand      = len_t'(last_pos) + len_t'(1);
        ws_next   = (seen && cand > ws_reg) ? cand : ws_reg;
        idx_p1    = len_t'(s1_idx_reg) + len_t'(1);
        wlen      = (ws_next <= idx_p1) ? (idx_p1 - ws_next) : '0;
        best_next = (wlen > best_reg) ? wlen : best_reg;
    end

    // table RAM: write on commit, registered read on transfer
    always_ff @(posedge clk)
    begin
        if (commit)
        begin
            last_pos_mem[s1_code_reg] <= s1_idx_reg;
        end
        if (accept)
        begin
            rd_data_reg <= last_pos_mem[in_code];
        end
    end

    // stage payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_code_reg    <= in_code;
            s1_idx_reg     <= pos_reg;
            s1_last_reg    <= end_of_string;
            s1_ovf_reg     <= ovf_item;
            s1_seen_reg    <= seen_reg[in_code] && !(commit && s1_last_reg);
            s1_fwd_reg     <= commit && !s1_last_reg && (s1_code_reg == in_code);
            s1_fwd_idx_reg <= s1_idx_reg;
        end
        if (commit)
        begin
            best_out_reg <= sat_len(best_next);
            wlen_out_reg <= sat_len(wlen);
            done_out_reg <= s1_last_reg;
            ovf_out_reg  <= s1_ovf_reg;
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            ovf_reg       <= 1'b0;
            s1_valid_reg  <= 1'b0;
            ws_reg        <= '0;
            best_reg      <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (end_of_string)
                begin
                    pos_reg <= '0;
                    ovf_reg <= 1'b0;
                end
                else
                begin
                    pos_reg <= at_max ? pos_reg : pos_reg + pos_t'(1);
                    ovf_reg <= ovf_item;
                end
            end
            if (accept)
                s1_valid_reg <= 1'b1;
            else if (commit)
                s1_valid_reg <= 1'b0;
            if (commit)
            begin
                if (s1_last_reg)
                begin
                    ws_reg   <= '0;
                    best_reg <= '0;
                    seen_reg <= '0;
                end
                else
                begin
                    ws_reg                <= ws_next;
                    best_reg              <= best_next;
                    seen_reg[s1_code_reg] <= 1'b1;
                end
            end
            out_valid_reg <= commit || (out_valid_reg && !out_ready);
        end
    end

    assign out_valid     = out_valid_reg;
    assign best_length   = best_out_reg;
    assign window_length = wlen_out_reg;
    assign string_done   = done_out_reg;
    assign overflow      = ovf_out_reg;

    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && out_valid_reg && !out_ready |-> !in_ready)
        else $error("input taken while compute stage is stalled");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        commit && s1_last_reg |=> (ws_reg == '0 && best_reg == '0 && seen_reg == '0))
        else $error("state not cleared after string end");

    a_best_covers_window: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> best_length >= window_length)
        else $error("best length below window length");

    a_pos_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_MAX)
        else $error("position counter beyond its limit");

endmodule
`default_nettype wire

// File: bench/tb_top.sv
// Self-checking bench for longest_unique_run_tracker: directed strings, then random strings.
// Results are checked against a run-length predictor kept in this file, or against typed directed rows.
// Depends on lurt_pkg and the RTL top level only.
`default_nettype none
module tb_top;
    import lurt_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 600000;
    localparam int unsigned DRAIN_CYCLES = 8;

    typedef struct packed {
        out_len_t best;
        out_len_t wlen;
        logic     done;
        logic     ovf;
    } run_result_t;

    typedef struct packed {
        logic [7:0]  code;
        logic        eos;
        logic        typed;
        run_result_t want;
    } string_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic [7:0] char_code = 8'h00;
    logic end_of_string = 1'b0;
    logic out_ready = 1'b0;
    logic in_ready;
    logic out_valid;
    out_len_t best_length;
    out_len_t window_length;
    logic string_done;
    logic overflow;

    longest_unique_run_tracker dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .char_code     (char_code),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .best_length   (best_length),
        .window_length (window_length),
        .string_done   (string_done),
        .overflow      (overflow)
    );

    int unsigned last_seen_at [ALPHABET];
    bit          seen_in_run [ALPHABET];
    int unsigned byte_index;
    int unsigned run_start;
    int unsigned best_run;
    bit          index_clipped;

    run_result_t pending_runs [$];
    run_result_t head_run;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;

    string_row_t directed_rows [24] = '{
        '{8'h00, 1'b0, 1'b1, '{16'd1, 16'd1, 1'b0, 1'b0}},
        '{8'hFF, 1'b0, 1'b1, '{16'd2, 16'd2, 1'b0, 1'b0}},
        '{8'h00, 1'b0, 1'b1, '{16'd2, 16'd2, 1'b0, 1'b0}},
        '{8'h00, 1'b1, 1'b1, '{16'd2, 16'd1, 1'b1, 1'b0}},
        '{8'h41, 1'b1, 1'b1, '{16'd1, 16'd1, 1'b1, 1'b0}},
        '{8'hFF, 1'b1, 1'b1, '{16'd1, 16'd1, 1'b1, 1'b0}},
        '{8'h61, 1'b0, 1'b0, '0},
        '{8'h62, 1'b0, 1'b0, '0},
        '{8'h63, 1'b0, 1'b0, '0},
        '{8'h61, 1'b0, 1'b0, '0},
        '{8'h62, 1'b0, 1'b0, '0},
        '{8'h63, 1'b0, 1'b0, '0},
        '{8'h62, 1'b0, 1'b0, '0},
        '{8'h62, 1'b1, 1'b0, '0},
        '{8'h70, 1'b0, 1'b0, '0},
        '{8'h77, 1'b0, 1'b0, '0},
        '{8'h77, 1'b0, 1'b0, '0},
        '{8'h6B, 1'b0, 1'b0, '0},
        '{8'h65, 1'b0, 1'b0, '0},
        '{8'h77, 1'b1, 1'b0, '0},
        '{8'h55, 1'b0, 1'b0, '0},
        '{8'hAA, 1'b0, 1'b0, '0},
        '{8'h0F, 1'b0, 1'b0, '0},
        '{8'hF0, 1'b1, 1'b0, '0}
    };

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic out_len_t clip_len(input int unsigned v);
        return (v > int'(OUT_MAX)) ? OUT_MAX : out_len_t'(v);
    endfunction

    function automatic void clear_run_state();
        foreach (seen_in_run[k])
        begin
            seen_in_run[k] = 1'b0;
            last_seen_at[k] = 0;
        end
        byte_index = 0;
        run_start = 0;
        best_run = 0;
        index_clipped = 1'b0;
    endfunction

    function automatic run_result_t predict_run(input logic [7:0] code_in, input logic eos);
        int unsigned sym;
        int unsigned idx;
        int unsigned cand;
        int unsigned wlen;
        run_result_t r;
        sym = code_in % ALPHABET;
        idx = byte_index;
        if (byte_index >= MAX_POS)
        begin
            idx = MAX_POS;
            index_clipped = 1'b1;
        end
        if (seen_in_run[sym])
        begin
            cand = last_seen_at[sym] + 1;
            if (cand > run_start)
                run_start = cand;
        end
        last_seen_at[sym] = idx;
        seen_in_run[sym] = 1'b1;
        wlen = (run_start <= idx + 1) ? idx + 1 - run_start : 0;
        if (wlen > best_run)
            best_run = wlen;
        if (byte_index < MAX_POS)
            byte_index++;
        r.best = clip_len(best_run);
        r.wlen = clip_len(wlen);
        r.done = eos;
        r.ovf = index_clipped;
        if (eos)
            clear_run_state();
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        $display("mismatch at cycle %0d: %s got %0d expected %0d",
                 cycle_count, what, got, want);
        mismatches++;
    endtask

    // hold valid and payload until the transfer, then book the expectation
    task automatic push_byte(input logic [7:0] code_in, input logic eos,
                             input logic typed, input run_result_t typed_want);
        run_result_t predicted;
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        char_code <= code_in;
        end_of_string <= eos;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = predict_run(code_in, eos);
        pending_runs.push_back(typed ? typed_want : predicted);
    endtask

    task automatic push_random_string(inout int unsigned sent);
        int unsigned kind;
        int unsigned len;
        int unsigned base;
        int unsigned span;
        logic [7:0] c;
        kind = $urandom_range(0, 9);
        len = (kind == 0) ? $urandom_range(200, 300) : $urandom_range(1, 24);
        base = $urandom_range(0, 255);
        span = $urandom_range(1, 40);
        for (int unsigned i = 0; i < len; i++)
        begin
            if (kind == 0 || kind == 9)
                c = ($urandom_range(0, 19) == 0) ? 8'($urandom) : 8'(base + i);
            else if (kind < 5)
                c = 8'($urandom);
            else
                c = 8'(base + $urandom_range(0, span));
            push_byte(c, i == len - 1, 1'b0, '0);
        end
        sent += len;
    endtask

    // drop valid and hold off until every expected result has arrived
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic run_random_phase(input int unsigned s_pct, input int unsigned r_pct,
                                    input int unsigned target);
        int unsigned sent;
        sent = 0;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        while (sent < target)
            push_random_string(sent);
        settle();
    endtask

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_runs.size() == 0)
            begin
                report_mismatch("result with nothing pending", best_length, 0);
            end
            else
            begin
                head_run = pending_runs.pop_front();
                if (best_length !== head_run.best)
                    report_mismatch("best_length", best_length, head_run.best);
                if (window_length !== head_run.wlen)
                    report_mismatch("window_length", window_length, head_run.wlen);
                if (string_done !== head_run.done)
                    report_mismatch("string_done", string_done, head_run.done);
                if (overflow !== head_run.ovf)
                    report_mismatch("overflow", overflow, head_run.ovf);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    initial
    begin
        clear_run_state();
        send_idle_pct = 7;
        recv_idle_pct = 80;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
            push_byte(directed_rows[r].code, directed_rows[r].eos,
                      directed_rows[r].typed, directed_rows[r].want);
        settle();

        run_random_phase(7, 80, 260);
        run_random_phase(80, 7, 260);
        run_random_phase(0, 0, 260);

        if (pending_runs.size() != 0)
            report_mismatch("results never delivered", 0, pending_runs.size());
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
`default_nettype wire

// File: sim.f
rtl/lurt_pkg.sv
rtl/longest_unique_run_tracker.sv
bench/tb_top.sv
